// ===== hdl/tcgw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgw_pkg: shared types and constants of the text console glyph writer
// Screen geometry, request and operation codes, job record, 8x8 font ROM.
// ----------------------------------------------------------------------------
package tcgw_pkg;

	// Geometry constants
	localparam int MARGIN         = 25;
	localparam int MAX_SCREEN_DIM = 2048;
	localparam int MIN_SCREEN_DIM = 64;
	localparam int LINE_STEP      = 9;
	localparam int GLYPH_ROWS     = 8;
	localparam int FIRST_GLYPH    = 32;
	localparam int GLYPH_COUNT    = 96;

	localparam logic [11:0] MARGIN_PX    = 12'(MARGIN);
	localparam logic [11:0] MARGIN_2X_PX = 12'(2 * MARGIN);
	localparam logic [11:0] LINE_STEP_PX = 12'(LINE_STEP);
	localparam logic [7:0]  NEWLINE_CODE = 8'd10;

	// Request codes
	localparam logic REQ_PRINT = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	// Operation codes
	localparam logic [1:0] OP_GLYPH_ROW  = 2'd0;
	localparam logic [1:0] OP_SCROLL     = 2'd1;
	localparam logic [1:0] OP_CLEAR_FILL = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_SCREEN_WIDTH    = 2'd0;
	localparam logic [1:0] CFG_SCREEN_HEIGHT   = 2'd1;
	localparam logic [1:0] CFG_BYTES_PER_PIXEL = 2'd2;

	// Effective screen geometry after clamping
	typedef struct packed {
		logic [11:0] width;
		logic [11:0] height;
		logic        bpp4;
	} tcgw_dims_t;

	// One request turned into framebuffer work
	typedef struct packed {
		logic        do_clear;
		logic        do_scroll;
		logic        do_glyph;
		logic [11:0] row;
		logic [11:0] col;
		logic [7:0]  code;
	} tcgw_job_t;

	// Font, one 64-bit word per glyph, top row in the upper byte
	localparam logic [63:0] GLYPH_ROM [GLYPH_COUNT] = '{
		{8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0},
		{8'd56,8'd56,8'd56,8'd56,8'd56,8'd0,8'd56,8'd56},
		{8'd108,8'd108,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0},
		{8'd0,8'd108,8'd254,8'd254,8'd108,8'd254,8'd254,8'd108},
		{8'd48,8'd126,8'd224,8'd124,8'd14,8'd254,8'd252,8'd48},
		{8'd98,8'd230,8'd204,8'd24,8'd48,8'd102,8'd206,8'd140},
		{8'd120,8'd220,8'd252,8'd120,8'd250,8'd222,8'd252,8'd118},
		{8'd28,8'd28,8'd56,8'd0,8'd0,8'd0,8'd0,8'd0},
		{8'd14,8'd28,8'd28,8'd28,8'd28,8'd28,8'd28,8'd14},
		{8'd112,8'd56,8'd56,8'd56,8'd56,8'd56,8'd56,8'd112},
		{8'd0,8'd0,8'd0,8'd230,8'd124,8'd56,8'd124,8'd206},
		{8'd0,8'd0,8'd28,8'd28,8'd127,8'd127,8'd28,8'd28},
		{8'd0,8'd0,8'd0,8'd0,8'd0,8'd28,8'd28,8'd56},
		{8'd0,8'd0,8'd0,8'd0,8'd124,8'd124,8'd0,8'd0},
		{8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd56,8'd56},
		{8'd28,8'd28,8'd56,8'd56,8'd112,8'd112,8'd224,8'd224},
		{8'd124,8'd254,8'd238,8'd238,8'd238,8'd254,8'd254,8'd124},
		{8'd56,8'd120,8'd248,8'd56,8'd56,8'd254,8'd254,8'd254},
		{8'd252,8'd254,8'd14,8'd60,8'd112,8'd254,8'd254,8'd254},
		{8'd252,8'd254,8'd14,8'd60,8'd14,8'd254,8'd254,8'd252},
		{8'd238,8'd238,8'd238,8'd254,8'd254,8'd14,8'd14,8'd14},
		{8'd254,8'd254,8'd224,8'd252,8'd14,8'd254,8'd254,8'd252},
		{8'd124,8'd252,8'd224,8'd252,8'd238,8'd254,8'd254,8'd124},
		{8'd252,8'd254,8'd14,8'd14,8'd28,8'd28,8'd56,8'd56},
		{8'd124,8'd254,8'd238,8'd124,8'd238,8'd254,8'd254,8'd124},
		{8'd124,8'd254,8'd238,8'd126,8'd14,8'd254,8'd254,8'd252},
		{8'd0,8'd0,8'd28,8'd28,8'd0,8'd28,8'd28,8'd28},
		{8'd0,8'd0,8'd28,8'd28,8'd0,8'd28,8'd28,8'd56},
		{8'd6,8'd14,8'd28,8'd56,8'd56,8'd28,8'd14,8'd6},
		{8'd0,8'd0,8'd124,8'd124,8'd0,8'd124,8'd124,8'd124},
		{8'd112,8'd56,8'd28,8'd14,8'd14,8'd28,8'd56,8'd112},
		{8'd124,8'd254,8'd206,8'd28,8'd56,8'd0,8'd56,8'd56},
		{8'd124,8'd198,8'd190,8'd182,8'd190,8'd182,8'd200,8'd126},
		{8'd124,8'd254,8'd238,8'd254,8'd238,8'd238,8'd238,8'd238},
		{8'd252,8'd254,8'd206,8'd252,8'd206,8'd254,8'd254,8'd252},
		{8'd124,8'd254,8'd238,8'd224,8'd238,8'd254,8'd254,8'd124},
		{8'd252,8'd254,8'd238,8'd238,8'd238,8'd254,8'd254,8'd252},
		{8'd254,8'd254,8'd224,8'd248,8'd224,8'd254,8'd254,8'd254},
		{8'd126,8'd254,8'd224,8'd248,8'd224,8'd224,8'd224,8'd224},
		{8'd126,8'd254,8'd224,8'd238,8'd238,8'd254,8'd254,8'd124},
		{8'd238,8'd238,8'd238,8'd254,8'd238,8'd238,8'd238,8'd238},
		{8'd254,8'd254,8'd56,8'd56,8'd56,8'd254,8'd254,8'd254},
		{8'd254,8'd254,8'd14,8'd14,8'd238,8'd254,8'd254,8'd124},
		{8'd238,8'd238,8'd252,8'd248,8'd252,8'd238,8'd238,8'd238},
		{8'd224,8'd224,8'd224,8'd224,8'd224,8'd254,8'd254,8'd126},
		{8'd130,8'd198,8'd238,8'd254,8'd254,8'd238,8'd238,8'd238},
		{8'd206,8'd238,8'd254,8'd254,8'd254,8'd254,8'd238,8'd230},
		{8'd124,8'd254,8'd238,8'd238,8'd238,8'd254,8'd254,8'd124},
		{8'd252,8'd254,8'd238,8'd238,8'd252,8'd224,8'd224,8'd224},
		{8'd124,8'd254,8'd238,8'd238,8'd254,8'd254,8'd252,8'd118},
		{8'd252,8'd254,8'd238,8'd238,8'd252,8'd238,8'd238,8'd238},
		{8'd126,8'd254,8'd224,8'd124,8'd14,8'd254,8'd254,8'd252},
		{8'd254,8'd254,8'd56,8'd56,8'd56,8'd56,8'd56,8'd56},
		{8'd238,8'd238,8'd238,8'd238,8'd238,8'd254,8'd254,8'd124},
		{8'd238,8'd238,8'd238,8'd238,8'd238,8'd238,8'd124,8'd56},
		{8'd238,8'd238,8'd238,8'd254,8'd254,8'd238,8'd198,8'd130},
		{8'd238,8'd238,8'd124,8'd56,8'd124,8'd238,8'd238,8'd238},
		{8'd238,8'd238,8'd124,8'd124,8'd56,8'd56,8'd112,8'd112},
		{8'd254,8'd254,8'd28,8'd56,8'd112,8'd254,8'd254,8'd254},
		{8'd124,8'd124,8'd112,8'd112,8'd112,8'd124,8'd124,8'd124},
		{8'd112,8'd112,8'd56,8'd56,8'd28,8'd28,8'd14,8'd14},
		{8'd124,8'd124,8'd28,8'd28,8'd28,8'd124,8'd124,8'd124},
		{8'd56,8'd124,8'd238,8'd198,8'd0,8'd0,8'd0,8'd0},
		{8'd0,8'd0,8'd0,8'd0,8'd0,8'd254,8'd254,8'd254},
		{8'd56,8'd56,8'd28,8'd0,8'd0,8'd0,8'd0,8'd0},
		{8'd0,8'd124,8'd254,8'd238,8'd254,8'd238,8'd238,8'd238},
		{8'd0,8'd252,8'd254,8'd206,8'd252,8'd206,8'd254,8'd252},
		{8'd0,8'd124,8'd254,8'd238,8'd224,8'd238,8'd254,8'd124},
		{8'd0,8'd252,8'd254,8'd238,8'd238,8'd238,8'd254,8'd252},
		{8'd0,8'd254,8'd254,8'd224,8'd248,8'd224,8'd254,8'd254},
		{8'd0,8'd126,8'd254,8'd224,8'd248,8'd224,8'd224,8'd224},
		{8'd0,8'd126,8'd254,8'd224,8'd238,8'd238,8'd254,8'd124},
		{8'd0,8'd238,8'd238,8'd238,8'd254,8'd238,8'd238,8'd238},
		{8'd0,8'd254,8'd254,8'd56,8'd56,8'd56,8'd254,8'd254},
		{8'd0,8'd254,8'd254,8'd14,8'd14,8'd238,8'd254,8'd124},
		{8'd0,8'd238,8'd238,8'd252,8'd248,8'd252,8'd238,8'd238},
		{8'd0,8'd224,8'd224,8'd224,8'd224,8'd224,8'd254,8'd126},
		{8'd0,8'd130,8'd198,8'd238,8'd254,8'd254,8'd238,8'd238},
		{8'd0,8'd206,8'd238,8'd254,8'd254,8'd254,8'd238,8'd230},
		{8'd0,8'd124,8'd254,8'd238,8'd238,8'd238,8'd254,8'd124},
		{8'd0,8'd252,8'd254,8'd238,8'd238,8'd252,8'd224,8'd224},
		{8'd0,8'd124,8'd254,8'd238,8'd238,8'd254,8'd252,8'd118},
		{8'd0,8'd252,8'd254,8'd238,8'd238,8'd252,8'd238,8'd238},
		{8'd0,8'd126,8'd254,8'd224,8'd124,8'd14,8'd254,8'd252},
		{8'd0,8'd254,8'd254,8'd56,8'd56,8'd56,8'd56,8'd56},
		{8'd0,8'd238,8'd238,8'd238,8'd238,8'd238,8'd254,8'd124},
		{8'd0,8'd238,8'd238,8'd238,8'd238,8'd238,8'd124,8'd56},
		{8'd0,8'd238,8'd238,8'd238,8'd254,8'd238,8'd198,8'd130},
		{8'd0,8'd238,8'd238,8'd124,8'd56,8'd124,8'd238,8'd238},
		{8'd0,8'd238,8'd238,8'd124,8'd124,8'd56,8'd56,8'd112},
		{8'd0,8'd254,8'd254,8'd28,8'd56,8'd112,8'd254,8'd254},
		{8'd60,8'd124,8'd112,8'd112,8'd112,8'd124,8'd124,8'd60},
		{8'd56,8'd56,8'd56,8'd0,8'd56,8'd56,8'd56,8'd56},
		{8'd120,8'd124,8'd28,8'd28,8'd28,8'd124,8'd124,8'd120},
		{8'd236,8'd254,8'd118,8'd0,8'd0,8'd0,8'd0,8'd0},
		{8'd0,8'd16,8'd56,8'd124,8'd254,8'd254,8'd254,8'd254}
	};

	// Font row lookup; codes below 32 or above 127 draw blank rows
	function automatic logic [7:0] glyph_row(logic [7:0] code, logic [2:0] h);
		logic [6:0]  idx;
		logic [63:0] bits;
		logic [2:0]  rh;
		idx  = code[6:0] - 7'(FIRST_GLYPH);
		bits = GLYPH_ROM[idx];
		rh   = 3'd7 - h;
		if (code[7] || (code[6:0] < 7'(FIRST_GLYPH))) begin
			return 8'd0;
		end
		return bits[{rh, 3'b000} +: 8];
	endfunction

endpackage

// ===== hdl/tcgw_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgw_ifs: request and result channel interfaces
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tcgw_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] char_code;

	modport source (output valid, output req_type, output char_code, input ready);
	modport sink (input valid, input req_type, input char_code, output ready);
endinterface

interface tcgw_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op_kind;
	logic [23:0] dest_offset;
	logic [23:0] src_offset;
	logic [24:0] byte_count;
	logic [7:0]  row_pattern;
	logic        last;

	modport source (output valid, output op_kind, output dest_offset, output src_offset,
		output byte_count, output row_pattern, output last, input ready);
	modport sink (input valid, input op_kind, input dest_offset, input src_offset,
		input byte_count, input row_pattern, input last, output ready);
endinterface

// ===== hdl/tcgw_cursor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgw_cursor: text cursor tracking
// Holds the cursor and turns each accepted request into a job record.
// ----------------------------------------------------------------------------
module tcgw_cursor (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               req_type,
	input  logic [7:0]         char_code,
	input  tcgw_pkg::tcgw_dims_t dims,
	output tcgw_pkg::tcgw_job_t  job,
	output logic               job_valid
);
	import tcgw_pkg::*;

	logic [11:0] row_q, col_q;
	logic [11:0] row_nxt, col_nxt;
	logic        scroll, newline, wrap;
	logic [11:0] row_s, col_s, col_adv;

	// Scroll check, then clear to the margins, newline, or column advance with wrap
	always_comb begin
		scroll  = row_q >= (dims.height - MARGIN_2X_PX);
		row_s   = row_q;
		col_s   = col_q;
		if (scroll) begin
			row_s = (row_q >= LINE_STEP_PX) ? row_q - LINE_STEP_PX : 12'd0;
			col_s = MARGIN_PX;
		end
		newline = char_code == NEWLINE_CODE;
		col_adv = col_s + LINE_STEP_PX;
		wrap    = col_adv > (dims.width - MARGIN_2X_PX);

		row_nxt = row_s;
		col_nxt = col_adv;
		priority if (req_type == REQ_CLEAR) begin
			row_nxt = MARGIN_PX;
			col_nxt = MARGIN_PX;
		end else if (newline || wrap) begin
			row_nxt = row_s + LINE_STEP_PX;
			col_nxt = MARGIN_PX;
		end else begin
			row_nxt = row_s;
			col_nxt = col_adv;
		end
	end

	// Job record for the result sequencer
	always_comb begin
		job.do_clear  = req_type == REQ_CLEAR;
		job.do_scroll = (req_type == REQ_PRINT) && scroll;
		job.do_glyph  = (req_type == REQ_PRINT) && !newline;
		job.row       = row_s;
		job.col       = col_s;
		job.code      = char_code;
		job_valid     = job.do_clear || job.do_scroll || job.do_glyph;
	end

	// Cursor registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= MARGIN_PX;
			col_q <= MARGIN_PX;
		end else if (accept) begin
			row_q <= row_nxt;
			col_q <= col_nxt;
		end
	end

endmodule

// ===== hdl/tcgw_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcgw_emit: result sequencer
// Holds one job, steps through its operations and fills the output register.
// ----------------------------------------------------------------------------
module tcgw_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  tcgw_pkg::tcgw_job_t  job_in,
	input  tcgw_pkg::tcgw_dims_t dims,
	output logic                 free,
	tcgw_res_if.source           res
);
	import tcgw_pkg::*;

	tcgw_job_t   job_s1;
	logic        job_valid_s1;
	logic        scroll_pend_q;
	logic [2:0]  step_q;

	logic        advance, last_cur;
	logic [1:0]  kind_cur;
	logic [12:0] mul_a;
	logic [24:0] prod;
	logic [25:0] glyph_sum;
	logic [27:0] glyph_dest;
	logic [27:0] area_count;
	logic [23:0] wm_dest, wm_src;
	logic [23:0] dest_cur, src_cur;
	logic [24:0] count_cur;
	logic [7:0]  pat_cur;

	logic        out_valid_q;
	logic [1:0]  op_kind_q;
	logic [23:0] dest_q, src_q;
	logic [24:0] count_q;
	logic [7:0]  pat_q;
	logic        last_q;

	function automatic logic [27:0] by_bpp(logic [25:0] v, logic bpp4);
		return bpp4 ? {v, 2'b00} : {1'b0, v, 1'b0};
	endfunction

	assign advance = job_valid_s1 && (!out_valid_q || res.ready);
	assign free    = !job_valid_s1 || (advance && last_cur);

	// Operation of the current step
	always_comb begin
		priority if (job_s1.do_clear) begin
			kind_cur = OP_CLEAR_FILL;
			last_cur = 1'b1;
		end else if (scroll_pend_q) begin
			kind_cur = OP_SCROLL;
			last_cur = !job_s1.do_glyph;
		end else begin
			kind_cur = OP_GLYPH_ROW;
			last_cur = step_q == 3'd7;
		end
	end

	// One shared multiplier: glyph row base, scroll area or screen area
	always_comb begin
		unique case (kind_cur)
			OP_CLEAR_FILL: mul_a = {1'b0, dims.height};
			OP_SCROLL:     mul_a = {1'b0, dims.height - MARGIN_2X_PX};
			default:       mul_a = {1'b0, job_s1.row} + 13'(step_q);
		endcase
		prod       = 25'(mul_a) * 25'(dims.width);
		glyph_sum  = 26'(prod) + 26'(job_s1.col);
		glyph_dest = by_bpp(glyph_sum, dims.bpp4);
		area_count = by_bpp(26'(prod), dims.bpp4);
		wm_dest    = 24'(by_bpp(26'(dims.width) * 26'(MARGIN), dims.bpp4));
		wm_src     = 24'(by_bpp(26'(dims.width) * 26'(MARGIN + LINE_STEP), dims.bpp4));
	end

	// Result fields
	always_comb begin
		unique case (kind_cur)
			OP_CLEAR_FILL: begin
				dest_cur  = 24'd0;
				src_cur   = 24'd0;
				count_cur = 25'(area_count);
				pat_cur   = 8'd0;
			end
			OP_SCROLL: begin
				dest_cur  = wm_dest;
				src_cur   = wm_src;
				count_cur = 25'(area_count);
				pat_cur   = 8'd0;
			end
			default: begin
				dest_cur  = glyph_dest[23:0];
				src_cur   = 24'd0;
				count_cur = 25'(by_bpp(26'(GLYPH_ROWS), dims.bpp4));
				pat_cur   = glyph_row(job_s1.code, step_q);
			end
		endcase
	end

	// Job register and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1  <= 1'b0;
			scroll_pend_q <= 1'b0;
			step_q        <= 3'd0;
		end else if (load) begin
			job_valid_s1  <= 1'b1;
			scroll_pend_q <= job_in.do_scroll;
			step_q        <= 3'd0;
		end else if (advance) begin
			if (last_cur) begin
				job_valid_s1 <= 1'b0;
			end else if (scroll_pend_q) begin
				scroll_pend_q <= 1'b0;
			end else begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_s1 <= job_in;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			op_kind_q <= kind_cur;
			dest_q    <= dest_cur;
			src_q     <= src_cur;
			count_q   <= count_cur;
			pat_q     <= pat_cur;
			last_q    <= last_cur;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.op_kind     = op_kind_q;
	assign res.dest_offset = dest_q;
	assign res.src_offset  = src_q;
	assign res.byte_count  = count_q;
	assign res.row_pattern = pat_q;
	assign res.last        = last_q;

endmodule

// ===== hdl/text_console_glyph_writer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_glyph_writer_unit: scrolling text console with 8x8 font
// Turns print and clear requests into framebuffer operations.
// ----------------------------------------------------------------------------
// The job is registered on accept, and each result then passes through the output register.
// Throughput: one result per cycle while res.ready allows; a character gives 8 rows,
// after a scroll if one is due; a clear gives 1 fill; a newline only a scroll if due.
// The result sequencer sets the pace; the next item enters as the last result goes.
// Reset: cursor to (25,25), registers to 640x480 at 4 bytes per pixel.
module text_console_glyph_writer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_wdata,
	tcgw_req_if.sink    req,
	tcgw_res_if.source  res
);
	import tcgw_pkg::*;

	logic [11:0] width_q, height_q;
	logic [2:0]  bpp_q;
	tcgw_dims_t  dims;
	tcgw_job_t   job;
	logic        job_valid;
	logic        accept;
	logic        free;

	function automatic logic [11:0] clamp_dim(logic [11:0] v);
		if (v < 12'(MIN_SCREEN_DIM)) begin
			return 12'(MIN_SCREEN_DIM);
		end
		if (v > 12'(MAX_SCREEN_DIM)) begin
			return 12'(MAX_SCREEN_DIM);
		end
		return v;
	endfunction

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 12'd640;
			height_q <= 12'd480;
			bpp_q    <= 3'd4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SCREEN_WIDTH:    width_q  <= cfg_wdata;
				CFG_SCREEN_HEIGHT:   height_q <= cfg_wdata;
				CFG_BYTES_PER_PIXEL: bpp_q    <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	// Effective geometry
	assign dims.width  = clamp_dim(width_q);
	assign dims.height = clamp_dim(height_q);
	assign dims.bpp4   = bpp_q[2];

	// Input handshake
	assign req.ready = free;
	assign accept    = req.valid && free;

	tcgw_cursor u_cursor (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req_type  (req.req_type),
		.char_code (req.char_code),
		.dims      (dims),
		.job       (job),
		.job_valid (job_valid)
	);

	tcgw_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept && job_valid),
		.job_in (job),
		.dims   (dims),
		.free   (free),
		.res    (res)
	);

endmodule
